FILE: rtl/sfim_pkg.sv
// ----------------------------------------------------------------------------
// SPI frame integrity monitor package
// Shared widths, verdict codes and the histogram update bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sfim_pkg;

  // Fixed field widths of the frame and the result beat.
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned HDR_W      = 4;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned OUT_CNT_W  = 16;
  localparam int unsigned HIST_DEPTH = 16;

  // Default width of the saturating counters.
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_CHANNEL = 1'b1;

  // Run verdict codes.
  typedef enum logic [1:0] {
    VERDICT_PASS       = 2'd0,
    VERDICT_STUCK_LOW  = 2'd1,
    VERDICT_STUCK_HIGH = 2'd2,
    VERDICT_WARN       = 2'd3
  } verdict_e;

  // Write-back request from the update stage to the histogram store.
  typedef struct packed {
    logic             en;
    logic             clear;
    logic [HDR_W-1:0] hdr;
  } hist_upd_t;

endpackage

`default_nettype wire

FILE: rtl/sfim_if.sv
// ----------------------------------------------------------------------------
// SPI frame integrity monitor channels
// Valid/ready channels for received frames and for run summaries.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfim_frame_if;
  logic                           valid;
  logic                           ready;
  logic [sfim_pkg::FRAME_W-1:0]   rx_frame;
  logic                           first_of_run;
  logic                           last_of_run;

  modport source (output valid, rx_frame, first_of_run, last_of_run, input ready);
  modport sink   (input valid, rx_frame, first_of_run, last_of_run, output ready);
endinterface

interface sfim_result_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      verdict;
  logic [sfim_pkg::OUT_CNT_W-1:0]  match_count;
  logic [sfim_pkg::OUT_CNT_W-1:0]  mismatch_count;
  logic [sfim_pkg::HDR_W-1:0]      most_seen_header;
  logic [sfim_pkg::OUT_CNT_W-1:0]  most_seen_count;
  logic [sfim_pkg::OUT_CNT_W-1:0]  stuck_zero_count;
  logic [sfim_pkg::OUT_CNT_W-1:0]  stuck_ones_count;
  logic [sfim_pkg::OUT_CNT_W-1:0]  repeat_count;
  logic [sfim_pkg::DATA_W-1:0]     data_min;
  logic [sfim_pkg::DATA_W-1:0]     data_max;
  logic [sfim_pkg::FRAME_W-1:0]    frame_min;
  logic [sfim_pkg::FRAME_W-1:0]    frame_max;

  modport source (output valid, verdict, match_count, mismatch_count, most_seen_header,
                  most_seen_count, stuck_zero_count, stuck_ones_count, repeat_count,
                  data_min, data_max, frame_min, frame_max, input ready);
  modport sink   (input valid, verdict, match_count, mismatch_count, most_seen_header,
                  most_seen_count, stuck_zero_count, stuck_ones_count, repeat_count,
                  data_min, data_max, frame_min, frame_max, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfim_hist.sv
// ----------------------------------------------------------------------------
// Header histogram store
// Synchronous memory of per-header counts with valid bits for run clears
// and forwarding of a write-back that lands on the edge of the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfim_hist #(
  parameter int unsigned CntW = sfim_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       lk_en_i,
  input  wire logic [sfim_pkg::HDR_W-1:0] lk_hdr_i,
  input  wire sfim_pkg::hist_upd_t        upd_i,
  input  wire logic [CntW-1:0]            upd_cnt_i,
  output logic      [CntW-1:0]            cnt_o
);
  import sfim_pkg::*;

  logic [CntW-1:0]       mem [HIST_DEPTH];
  logic [CntW-1:0]       rd_q;
  logic [CntW-1:0]       fwd_q;
  logic                  hit_q;
  logic [HDR_W-1:0]      hdr_q;
  logic [HIST_DEPTH-1:0] valid_q;

  // Memory write-back and registered lookup read.
  always_ff @(posedge clk_i) begin
    if (upd_i.en) begin
      mem[upd_i.hdr] <= upd_cnt_i;
    end
    if (lk_en_i) begin
      rd_q <= mem[lk_hdr_i];
    end
  end

  // Forwarding tag, last written count and per-entry valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      hdr_q   <= '0;
      fwd_q   <= '0;
      valid_q <= '0;
    end else begin
      if (lk_en_i) begin
        hit_q <= upd_i.en && (upd_i.hdr == lk_hdr_i);
        hdr_q <= lk_hdr_i;
      end
      if (upd_i.en) begin
        fwd_q <= upd_cnt_i;
        if (upd_i.clear) begin
          valid_q <= HIST_DEPTH'(1) << upd_i.hdr;
        end else begin
          valid_q[upd_i.hdr] <= 1'b1;
        end
      end
    end
  end

  // An entry not written since the last run clear reads as zero.
  assign cnt_o = hit_q ? fwd_q : (valid_q[hdr_q] ? rd_q : '0);

endmodule

`default_nettype wire

FILE: rtl/spi_frame_integrity_monitor_top.sv
// A frame accepted into the stage register is counted as it leaves the stage; a
// summary beat loads into the output register as its last frame leaves, which
// waits while an earlier summary is held. Throughput: one frame per cycle unless
// a last frame waits on a held summary; the histogram read in the accept cycle
// and its write-back in the update cycle overlap through a forwarding path.
// Reset clears every statistic and both configuration registers at once.
// ----------------------------------------------------------------------------
// SPI frame integrity monitor
// Keeps header, match, stuck and range statistics over a run of frames and
// returns a summary with a verdict after the last frame of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_frame_integrity_monitor_top #(
  parameter int unsigned COUNT_BITS = sfim_pkg::COUNT_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [sfim_pkg::HDR_W-1:0]   cfg_data_i,
  sfim_frame_if.sink                        frm_i,
  sfim_result_if.source                     res_o
);
  import sfim_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic             mode_q;
  logic [HDR_W-1:0] chan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      chan_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:    mode_q <= cfg_data_i[0];
        CFG_CHANNEL: chan_q <= cfg_data_i;
        default:     mode_q <= mode_q;
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_valid_q, s1_first_q, s1_last_q;
  logic [FRAME_W-1:0] s1_frame_q;
  logic res_valid_q, res_free, s1_adv, in_acc;

  assign res_free    = !res_valid_q || res_o.ready;
  assign s1_adv      = s1_valid_q && (!s1_last_q || res_free);
  assign frm_i.ready = !s1_valid_q || s1_adv;
  assign in_acc      = frm_i.valid && frm_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_frame_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_first_q <= frm_i.first_of_run;
        s1_last_q  <= frm_i.last_of_run;
        s1_frame_q <= frm_i.rx_frame;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Run statistics.
  logic [HDR_W-1:0]      best_hdr_q;
  logic [COUNT_BITS-1:0] best_cnt_q, good_q, bad_q, zero_q, ones_q, rep_q;
  logic                  seen_q, all_zero_q, all_ones_q;
  logic [FRAME_W-1:0]    prev_q, lof_q, hif_q;
  logic [HDR_W-1:0]      ref_q;
  logic [DATA_W-1:0]     lod_q, hid_q;

  // Values at the start of this frame, with a run clear applied.
  logic [HDR_W-1:0]      b_best_hdr, b_ref;
  logic [COUNT_BITS-1:0] b_best_cnt, b_good, b_bad, b_zero, b_ones, b_rep;
  logic [FRAME_W-1:0]    b_prev, b_lof, b_hif;
  logic [DATA_W-1:0]     b_lod, b_hid;
  logic                  b_allz, b_allo, opening;

  always_comb begin
    b_best_hdr = s1_first_q ? '0 : best_hdr_q;
    b_best_cnt = s1_first_q ? '0 : best_cnt_q;
    b_good     = s1_first_q ? '0 : good_q;
    b_bad      = s1_first_q ? '0 : bad_q;
    b_zero     = s1_first_q ? '0 : zero_q;
    b_ones     = s1_first_q ? '0 : ones_q;
    b_rep      = s1_first_q ? '0 : rep_q;
    b_prev     = s1_first_q ? '1 : prev_q;
    b_ref      = s1_first_q ? '0 : ref_q;
    b_lod      = s1_first_q ? '1 : lod_q;
    b_hid      = s1_first_q ? '0 : hid_q;
    b_lof      = s1_first_q ? '1 : lof_q;
    b_hif      = s1_first_q ? '0 : hif_q;
    b_allz     = s1_first_q ? 1'b1 : all_zero_q;
    b_allo     = s1_first_q ? 1'b1 : all_ones_q;
    opening    = s1_first_q || !seen_q;
  end

  // Histogram store.
  hist_upd_t             upd;
  logic [COUNT_BITS-1:0] hist_rd, hist_old, hist_new;
  logic [HDR_W-1:0]      hdr;
  logic [DATA_W-1:0]     data;

  assign hdr  = s1_frame_q[FRAME_W-1 -: HDR_W];
  assign data = s1_frame_q[FRAME_W-HDR_W-1 -: DATA_W];

  assign upd.en    = s1_adv;
  assign upd.clear = s1_first_q;
  assign upd.hdr   = hdr;

  sfim_hist #(
    .CntW (COUNT_BITS)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lk_en_i   (in_acc),
    .lk_hdr_i  (frm_i.rx_frame[FRAME_W-1 -: HDR_W]),
    .upd_i     (upd),
    .upd_cnt_i (hist_new),
    .cnt_o     (hist_rd)
  );

  assign hist_old = s1_first_q ? '0 : hist_rd;
  assign hist_new = (hist_old == CNT_MAX) ? hist_old : hist_old + 1'b1;

  // Per-frame updates.
  logic                  take_best, judge, good_hit, is_zero, is_ones, is_rep;
  logic [HDR_W-1:0]      n_best_hdr;
  logic [COUNT_BITS-1:0] n_best_cnt, n_good, n_bad, n_zero, n_ones, n_rep;
  logic [FRAME_W-1:0]    n_lof, n_hif;
  logic [DATA_W-1:0]     n_lod, n_hid;
  logic                  n_allz, n_allo;

  always_comb begin
    take_best  = (hist_new > b_best_cnt) || ((hist_new == b_best_cnt) && (hdr < b_best_hdr));
    n_best_hdr = take_best ? hdr : b_best_hdr;
    n_best_cnt = take_best ? hist_new : b_best_cnt;

    judge    = !mode_q || !opening;
    good_hit = mode_q ? (hdr == b_ref) : (hdr == chan_q);
    n_good   = (judge && good_hit && (b_good != CNT_MAX)) ? b_good + 1'b1 : b_good;
    n_bad    = (judge && !good_hit && (b_bad != CNT_MAX)) ? b_bad + 1'b1 : b_bad;

    is_zero = (s1_frame_q == '0);
    is_ones = (s1_frame_q == '1);
    is_rep  = !opening && (s1_frame_q == b_prev);
    n_zero  = (is_zero && (b_zero != CNT_MAX)) ? b_zero + 1'b1 : b_zero;
    n_ones  = (is_ones && (b_ones != CNT_MAX)) ? b_ones + 1'b1 : b_ones;
    n_rep   = (is_rep && (b_rep != CNT_MAX)) ? b_rep + 1'b1 : b_rep;
    n_allz  = b_allz && is_zero;
    n_allo  = b_allo && is_ones;

    n_lof = (s1_frame_q < b_lof) ? s1_frame_q : b_lof;
    n_hif = (s1_frame_q > b_hif) ? s1_frame_q : b_hif;
    n_lod = (data < b_lod) ? data : b_lod;
    n_hid = (data > b_hid) ? data : b_hid;
  end

  // Statistics registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_hdr_q <= '0;
      best_cnt_q <= '0;
      good_q     <= '0;
      bad_q      <= '0;
      zero_q     <= '0;
      ones_q     <= '0;
      rep_q      <= '0;
      seen_q     <= 1'b0;
      prev_q     <= '1;
      ref_q      <= '0;
      lod_q      <= '1;
      hid_q      <= '0;
      lof_q      <= '1;
      hif_q      <= '0;
      all_zero_q <= 1'b1;
      all_ones_q <= 1'b1;
    end else if (s1_adv) begin
      best_hdr_q <= n_best_hdr;
      best_cnt_q <= n_best_cnt;
      good_q     <= n_good;
      bad_q      <= n_bad;
      zero_q     <= n_zero;
      ones_q     <= n_ones;
      rep_q      <= n_rep;
      seen_q     <= 1'b1;
      prev_q     <= s1_frame_q;
      ref_q      <= hdr;
      lod_q      <= n_lod;
      hid_q      <= n_hid;
      lof_q      <= n_lof;
      hif_q      <= n_hif;
      all_zero_q <= n_allz;
      all_ones_q <= n_allo;
    end
  end

  // Verdict: stuck-low over stuck-high over warning.
  verdict_e verdict;

  always_comb begin
    if (n_allz) begin
      verdict = VERDICT_STUCK_LOW;
    end else if (n_allo) begin
      verdict = VERDICT_STUCK_HIGH;
    end else if (n_bad != '0) begin
      verdict = VERDICT_WARN;
    end else begin
      verdict = VERDICT_PASS;
    end
  end

  // Output register for the summary beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      res_o.verdict          <= verdict;
      res_o.match_count      <= OUT_CNT_W'(n_good);
      res_o.mismatch_count   <= OUT_CNT_W'(n_bad);
      res_o.most_seen_header <= n_best_hdr;
      res_o.most_seen_count  <= OUT_CNT_W'(n_best_cnt);
      res_o.stuck_zero_count <= OUT_CNT_W'(n_zero);
      res_o.stuck_ones_count <= OUT_CNT_W'(n_ones);
      res_o.repeat_count     <= OUT_CNT_W'(n_rep);
      res_o.data_min         <= n_lod;
      res_o.data_max         <= n_hid;
      res_o.frame_min        <= n_lof;
      res_o.frame_max        <= n_hif;
    end
  end

  assign res_o.valid = res_valid_q;

`ifndef SYNTHESIS
  // The input side only stalls behind a last frame that cannot hand off its summary.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frm_i.ready |-> (s1_valid_q && s1_last_q && res_valid_q && !res_o.ready))
    else $error("input stalled without a blocked summary");

  // The tracked best count never falls below the count just written back.
  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (best_cnt_q >= $past(hist_new)))
    else $error("best header count below a histogram entry");

  // Once a frame is counted the frame and data ranges are ordered.
  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (lof_q <= hif_q && lod_q <= hid_q))
    else $error("minimum above maximum");
`endif

endmodule

`default_nettype wire

FILE: test/spi_frame_integrity_monitor_top_tb.sv
// ----------------------------------------------------------------------------
// SPI frame integrity monitor testbench
// Sends runs of frames with random first and last flags under both analysis
// modes and many channel settings. An in-bench predictor tracks the run
// statistics, and every summary beat is compared with the oldest prediction,
// field by field. Idle gaps fall on both channels, and one long receiver
// hold-off fills the block.
// ----------------------------------------------------------------------------

module spi_frame_integrity_monitor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfim_pkg::*;

  localparam int unsigned CNT_BITS      = COUNT_BITS_DEF;
  localparam int          LIMIT_CYCLES  = 1_000_000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          END_CYCLES    = 8;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          IDLE_END      = 1650;
  localparam int          RANDOM_END    = 1950;

  typedef logic [CNT_BITS-1:0] count_t;

  typedef enum {RUN_MIXED, RUN_CLEAN, RUN_ZERO, RUN_ONES} run_style_e;

  // One run summary as it appears on the result channel.
  typedef struct {
    verdict_e          verdict;
    logic [OUT_CNT_W-1:0] match_count;
    logic [OUT_CNT_W-1:0] mismatch_count;
    logic [HDR_W-1:0]     most_seen_header;
    logic [OUT_CNT_W-1:0] most_seen_count;
    logic [OUT_CNT_W-1:0] stuck_zero_count;
    logic [OUT_CNT_W-1:0] stuck_ones_count;
    logic [OUT_CNT_W-1:0] repeat_count;
    logic [DATA_W-1:0]    data_min;
    logic [DATA_W-1:0]    data_max;
    logic [FRAME_W-1:0]   frame_min;
    logic [FRAME_W-1:0]   frame_max;
  } run_summary_t;

  // Tracks the run statistics of the block and holds the summaries still due.
  class frame_run_tracker;
    count_t             hist[HIST_DEPTH];
    logic [HDR_W-1:0]   top_hdr;
    count_t             top_cnt;
    count_t             match_hits;
    count_t             mismatches;
    count_t             zeros;
    count_t             ones;
    count_t             repeats;
    count_t             seen;
    logic [FRAME_W-1:0] prev_frame;
    logic [HDR_W-1:0]   last_hdr;
    logic [DATA_W-1:0]  dmin;
    logic [DATA_W-1:0]  dmax;
    logic [FRAME_W-1:0] fmin;
    logic [FRAME_W-1:0] fmax;
    logic               only_zero;
    logic               only_ones;
    logic               nibble_mode;
    logic [HDR_W-1:0]   want_chan;
    run_summary_t       summaries_due[$];
    int                 errors;

    function new();
      nibble_mode = 1'b0;
      want_chan   = '0;
      errors      = 0;
      clear_stats();
    endfunction

    function count_t bump(count_t c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void clear_stats();
      foreach (hist[i]) hist[i] = '0;
      top_hdr    = '0;
      top_cnt    = '0;
      match_hits = '0;
      mismatches = '0;
      zeros      = '0;
      ones       = '0;
      repeats    = '0;
      seen       = '0;
      prev_frame = 16'hFFFF;
      last_hdr   = '0;
      dmin       = 8'hFF;
      dmax       = '0;
      fmin       = 16'hFFFF;
      fmax       = '0;
      only_zero  = 1'b1;
      only_ones  = 1'b1;
    endfunction

    function void set_reg(logic idx, logic [HDR_W-1:0] value);
      if (idx == CFG_MODE) begin
        nibble_mode = value[0];
      end else begin
        want_chan = value;
      end
    endfunction

    // Notes one accepted frame beat and predicts its summary on a last frame.
    function void take_frame(logic [FRAME_W-1:0] frame, logic is_first, logic is_last);
      logic [HDR_W-1:0]  hdr;
      logic [DATA_W-1:0] data;
      logic              opening;
      count_t            c;
      run_summary_t      s;
      hdr  = frame[15:12];
      data = frame[11:4];
      if (is_first) clear_stats();
      opening = (seen == '0);

      if (frame < fmin) fmin = frame;
      if (frame > fmax) fmax = frame;
      if (data < dmin) dmin = data;
      if (data > dmax) dmax = data;

      // Ties on the histogram go to the lower header.
      c = bump(hist[hdr]);
      hist[hdr] = c;
      if (c > top_cnt || (c == top_cnt && hdr < top_hdr)) begin
        top_cnt = c;
        top_hdr = hdr;
      end

      // In nibble mode the opening frame of a run only sets the nibble reference.
      if (!nibble_mode) begin
        if (hdr == want_chan) match_hits = bump(match_hits);
        else mismatches = bump(mismatches);
      end else if (!opening) begin
        if (hdr == last_hdr) match_hits = bump(match_hits);
        else mismatches = bump(mismatches);
      end
      last_hdr = hdr;

      if (frame == 16'h0000) zeros = bump(zeros);
      else only_zero = 1'b0;
      if (frame == 16'hFFFF) ones = bump(ones);
      else only_ones = 1'b0;
      if (!opening && frame == prev_frame) repeats = bump(repeats);
      prev_frame = frame;
      seen = bump(seen);

      if (!is_last) return;

      if (only_zero) s.verdict = VERDICT_STUCK_LOW;
      else if (only_ones) s.verdict = VERDICT_STUCK_HIGH;
      else if (mismatches != '0) s.verdict = VERDICT_WARN;
      else s.verdict = VERDICT_PASS;
      s.match_count      = OUT_CNT_W'(match_hits);
      s.mismatch_count   = OUT_CNT_W'(mismatches);
      s.most_seen_header = top_hdr;
      s.most_seen_count  = OUT_CNT_W'(top_cnt);
      s.stuck_zero_count = OUT_CNT_W'(zeros);
      s.stuck_ones_count = OUT_CNT_W'(ones);
      s.repeat_count     = OUT_CNT_W'(repeats);
      s.data_min         = dmin;
      s.data_max         = dmax;
      s.frame_min        = fmin;
      s.frame_max        = fmax;
      summaries_due.insert(summaries_due.size(), s);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares one summary beat with the oldest prediction.
    function void check_summary(run_summary_t got);
      run_summary_t want;
      if (summaries_due.size() == 0) begin
        $error("summary beat with no run summary due");
        errors++;
        return;
      end
      want = summaries_due.pop_front();
      check_field("verdict", 16'(want.verdict), 16'(got.verdict));
      check_field("match_count", want.match_count, got.match_count);
      check_field("mismatch_count", want.mismatch_count, got.mismatch_count);
      check_field("most_seen_header", 16'(want.most_seen_header), 16'(got.most_seen_header));
      check_field("most_seen_count", want.most_seen_count, got.most_seen_count);
      check_field("stuck_zero_count", want.stuck_zero_count, got.stuck_zero_count);
      check_field("stuck_ones_count", want.stuck_ones_count, got.stuck_ones_count);
      check_field("repeat_count", want.repeat_count, got.repeat_count);
      check_field("data_min", 16'(want.data_min), 16'(got.data_min));
      check_field("data_max", 16'(want.data_max), 16'(got.data_max));
      check_field("frame_min", want.frame_min, got.frame_min);
      check_field("frame_max", want.frame_max, got.frame_max);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [HDR_W-1:0] cfg_data_i;

  sfim_frame_if  frm ();
  sfim_result_if res ();

  frame_run_tracker tracker = new();

  logic             cur_mode;
  logic [HDR_W-1:0] cur_chan;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               frames_sent;
  int               hold_asked;
  int               hold_served;
  int               cycle_cnt;
  run_summary_t     got_summary;

  spi_frame_integrity_monitor_top #(
    .COUNT_BITS (CNT_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frm_i      (frm),
    .res_o      (res)
  );

  // 100 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run watchdog.
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Watch both channels and feed every accepted beat to the tracker.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frm.valid && frm.ready) begin
        tracker.take_frame(frm.rx_frame, frm.first_of_run, frm.last_of_run);
      end
      if (res.valid && res.ready) begin
        got_summary.verdict          = verdict_e'(res.verdict);
        got_summary.match_count      = res.match_count;
        got_summary.mismatch_count   = res.mismatch_count;
        got_summary.most_seen_header = res.most_seen_header;
        got_summary.most_seen_count  = res.most_seen_count;
        got_summary.stuck_zero_count = res.stuck_zero_count;
        got_summary.stuck_ones_count = res.stuck_ones_count;
        got_summary.repeat_count     = res.repeat_count;
        got_summary.data_min         = res.data_min;
        got_summary.data_max         = res.data_max;
        got_summary.frame_min        = res.frame_min;
        got_summary.frame_max        = res.frame_max;
        tracker.check_summary(got_summary);
      end
    end
  end

  // Summary receiver: random stall bursts, plus long hold-offs on request.
  initial begin
    hold_served = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served++;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Offers one frame beat and returns at the edge that accepts it.
  task automatic send_frame(logic [FRAME_W-1:0] frame, logic is_first, logic is_last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      frm.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    frm.valid        <= 1'b1;
    frm.rx_frame     <= frame;
    frm.first_of_run <= is_first;
    frm.last_of_run  <= is_last;
    do @(posedge clk_i); while (frm.ready !== 1'b1);
    frames_sent++;
  endtask

  // Waits until every summary has come back and the block has gone quiet.
  task automatic settle(int extra);
    frm.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.summaries_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [HDR_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, value);
    if (idx == CFG_MODE) begin
      cur_mode = value[0];
    end else begin
      cur_chan = value;
    end
  endtask

  // Sends one run; mixed runs also carry stray flags in the middle.
  task automatic send_run(int len, bit open_flag, bit close_flag, run_style_e style);
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] prev;
    logic [HDR_W-1:0]   hdr;
    logic               f;
    logic               l;
    int                 r;
    if (cur_mode || $urandom_range(0, 3) == 0) hdr = HDR_W'($urandom_range(0, 15));
    else hdr = cur_chan;
    prev = FRAME_W'($urandom);
    for (int i = 0; i < len; i++) begin
      f = (i == 0) && open_flag;
      l = (i == len - 1) && close_flag;
      case (style)
        RUN_ZERO:  frame = 16'h0000;
        RUN_ONES:  frame = 16'hFFFF;
        RUN_CLEAN: frame = {hdr, 12'($urandom)};
        default: begin
          r = $urandom_range(0, 99);
          if (r < 55) frame = {hdr, 12'($urandom)};
          else if (r < 65) frame = prev;
          else if (r < 72) frame = 16'h0000;
          else if (r < 79) frame = 16'hFFFF;
          else frame = FRAME_W'($urandom);
          if ($urandom_range(0, 49) == 0) f = 1'b1;
          if ($urandom_range(0, 49) == 0) l = 1'b1;
        end
      endcase
      send_frame(frame, f, l);
      prev = frame;
    end
  endtask

  // A few runs of random shape and length.
  task automatic random_phase(int runs);
    int         pick;
    int         len;
    run_style_e style;
    for (int n = 0; n < runs; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) style = RUN_MIXED;
      else if (pick < 82) style = RUN_CLEAN;
      else if (pick < 91) style = RUN_ZERO;
      else style = RUN_ONES;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      send_run(len, $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0, style);
    end
  endtask

  // New register settings between phases, extremes favored.
  task automatic reconfigure();
    logic [HDR_W-1:0] chan;
    if ($urandom_range(0, 2) != 0) write_reg(CFG_MODE, HDR_W'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 3))
        0:       chan = '0;
        1:       chan = '1;
        default: chan = HDR_W'($urandom_range(0, 15));
      endcase
      write_reg(CFG_CHANNEL, chan);
    end
  endtask

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  // Main sequence.
  initial begin
    frm.valid        <= 1'b0;
    frm.rx_frame     <= '0;
    frm.first_of_run <= 1'b0;
    frm.last_of_run  <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_MODE;
    cfg_data_i       <= '0;
    rst_ni           <= 1'b0;
    cur_mode    = 1'b0;
    cur_chan    = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    frames_sent = 0;
    hold_asked  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed runs in channel mode on channel 0.
    write_reg(CFG_MODE, 4'd0);
    write_reg(CFG_CHANNEL, 4'd0);
    send_frame(16'h0000, 1'b1, 1'b1);
    send_frame(16'hFFFF, 1'b1, 1'b0);
    send_frame(16'hFFFF, 1'b0, 1'b1);
    send_frame(16'h0000, 1'b1, 1'b0);
    send_frame(16'hFFFF, 1'b0, 1'b1);
    // Headers 3 and 1 tie; the lower one wins.
    send_frame(16'h3FF0, 1'b1, 1'b0);
    send_frame(16'h1000, 1'b0, 1'b1);
    send_frame(16'h0123, 1'b1, 1'b0);
    send_frame(16'h0FF5, 1'b0, 1'b0);
    send_frame(16'h0004, 1'b0, 1'b1);
    // No first flag, so the previous run keeps accumulating.
    send_frame(16'h0456, 1'b0, 1'b1);
    settle(SETTLE_CYCLES);

    // Nibble mode: the opening frame only sets the reference.
    write_reg(CFG_MODE, 4'd1);
    write_reg(CFG_CHANNEL, 4'd15);
    send_frame(16'h5111, 1'b1, 1'b0);
    send_frame(16'h5222, 1'b0, 1'b0);
    send_frame(16'h6333, 1'b0, 1'b0);
    send_frame(16'h6333, 1'b0, 1'b1);
    // Mode switched back to channel mode in the middle of a run.
    send_frame(16'hF000, 1'b1, 1'b0);
    send_frame(16'hF001, 1'b0, 1'b0);
    settle(SETTLE_CYCLES);
    write_reg(CFG_MODE, 4'd0);
    send_frame(16'hF002, 1'b0, 1'b0);
    send_frame(16'h1000, 1'b0, 1'b1);
    settle(SETTLE_CYCLES);

    // Long receiver hold-off while single-frame runs keep coming.
    hold_asked++;
    for (int i = 0; i < 60; i++) send_frame(FRAME_W'($urandom), 1'b1, 1'b1);
    settle(SETTLE_CYCLES);

    // Random phases with idling on both sides.
    while (frames_sent < IDLE_END) begin
      reconfigure();
      tx_idle_pct = pick_idle();
      rx_idle_pct = pick_idle();
      random_phase($urandom_range(3, 10));
      settle(SETTLE_CYCLES);
    end

    // Closing phases at full rate.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (frames_sent < RANDOM_END) begin
      reconfigure();
      random_phase($urandom_range(3, 10));
      settle(SETTLE_CYCLES);
    end
    settle(END_CYCLES);

    if (tracker.errors == 0 && tracker.summaries_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
